// ===== hw/rtl/gda_pkg.sv =====
// Shared types, codes and calendar tables for the Gregorian date adder.
`timescale 1ns / 1ps

package gda_pkg;

    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMOUNT_W = 15;
    localparam int OP_W     = 3;
    // Remaining day count: amount times seven
    localparam int REM_W    = AMOUNT_W + 3;
    // Year multiplier is at most 1000
    localparam int MULT_W   = 10;
    localparam int PROD_W   = AMOUNT_W + MULT_W;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 15'd32767;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DAYS       = 3'd0;
    localparam logic [OP_W-1:0] OP_WEEKS      = 3'd1;
    localparam logic [OP_W-1:0] OP_YEARS      = 3'd2;
    localparam logic [OP_W-1:0] OP_DECADES    = 3'd3;
    localparam logic [OP_W-1:0] OP_CENTURIES  = 3'd4;
    localparam logic [OP_W-1:0] OP_MILLENNIA  = 3'd5;

    // Divide-by-25 via reciprocal: floor(y * 5243 / 2^17) is exact below 2^15
    localparam int                DIV25_SHIFT = 17;
    localparam logic [12:0]       DIV25_MUL   = 13'd5243;
    localparam int                DIV25_PW    = YEAR_W + 13;
    localparam int                DIV25_QW    = DIV25_PW - DIV25_SHIFT;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [AMOUNT_W-1:0] amount;
        logic [YEAR_W-1:0]   in_year;
        logic [MONTH_W-1:0]  in_month;
        logic [DAY_W-1:0]    in_day;
    } gda_cmd_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic               overflow;
        logic               invalid;
    } gda_result_t;

    // Outcome of one month step of the day walker
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [REM_W-1:0]   rem;
        logic               fin;
        logic               ovf;
        logic               year_inc;
    } gda_step_t;

    // Length of a month; codes outside 1..12 read as 31
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Year multiplier for the year-based operations
    function automatic logic [MULT_W-1:0] year_mult(input logic [OP_W-1:0] op);
        logic [MULT_W-1:0] mul;
        case (op)
            OP_DECADES:   mul = 10'd10;
            OP_CENTURIES: mul = 10'd100;
            OP_MILLENNIA: mul = 10'd1000;
            default:      mul = 10'd1;
        endcase
        return mul;
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_adder.sv =====
// Top level of the Gregorian date adder: command port, sequencer and result register.
//
//  Channel   Signals                 Direction  Handshake
//  command   start, busy, cmd        in         taken when start is high and busy is low
//  result    done, result            out        one-cycle strobe, no back-pressure
//
//  Sequence after the accept cycle: the leap evaluator is waited on in LP1 and LP2, then
//  CHECK ends an invalid date or unknown op; a year-based add runs YMUL and YADD and, unless
//  the year saturates, waits on the leap evaluator again and clamps the day in FIX. A day or
//  week add steps one month at a time in DAYS and waits on the leap evaluator at each year
//  boundary crossed. The month step unit and the two-stage leap evaluator drive these steps.
//  Reset clears the sequencer and the strobe; results are never stalled.
`timescale 1ns / 1ps

module gregorian_date_adder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gda_pkg::gda_cmd_t    cmd,
    output logic                 done,
    output gda_pkg::gda_result_t result
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LP1   = 3'd1;
    localparam logic [2:0] ST_LP2   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DAYS  = 3'd4;
    localparam logic [2:0] ST_YMUL  = 3'd5;
    localparam logic [2:0] ST_YADD  = 3'd6;
    localparam logic [2:0] ST_FIX   = 3'd7;

    // Where to go once the leap flag is valid
    localparam logic [1:0] RET_CHECK = 2'd0;
    localparam logic [1:0] RET_DAYS  = 2'd1;
    localparam logic [1:0] RET_FIX   = 2'd2;

    logic [2:0]                    state_reg, state_next;
    logic [1:0]                    ret_reg, ret_next;
    logic                          done_reg, done_next;
    logic [gda_pkg::OP_W-1:0]      op_reg, op_next;
    logic [gda_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [gda_pkg::YEAR_W-1:0]    year_reg, year_next;
    logic [gda_pkg::MONTH_W-1:0]   month_reg, month_next;
    logic [gda_pkg::DAY_W-1:0]     day_reg, day_next;
    logic                          ovf_reg, ovf_next;
    logic                          inv_reg, inv_next;
    logic [gda_pkg::PROD_W-1:0]    prod_reg, prod_next;

    logic                          leap;
    gda_pkg::gda_step_t            step;
    logic [gda_pkg::DAY_W-1:0]     len;
    logic [gda_pkg::PROD_W:0]      new_year;
    logic [gda_pkg::REM_W-1:0]     weeks;

    gda_leap u_leap (
        .clk   (clk),
        .rst_n (rst_n),
        .year  (year_reg),
        .leap  (leap)
    );

    gda_step u_step (
        .year  (year_reg),
        .month (month_reg),
        .day   (day_reg),
        .rem   (rem_reg),
        .leap  (leap),
        .step  (step)
    );

    // Sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        rem_next   = rem_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        ovf_next   = ovf_reg;
        inv_next   = inv_reg;
        prod_next  = prod_reg;

        len      = gda_pkg::month_days(month_reg, leap);
        new_year = {{(gda_pkg::PROD_W + 1 - gda_pkg::YEAR_W){1'b0}}, year_reg}
                 + {1'b0, prod_reg};
        weeks    = {cmd.amount, 3'b000} - {3'b000, cmd.amount};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd.op;
                    rem_next   = (cmd.op == gda_pkg::OP_WEEKS) ? weeks
                               : {3'b000, cmd.amount};
                    year_next  = cmd.in_year;
                    month_next = cmd.in_month;
                    day_next   = cmd.in_day;
                    ovf_next   = 1'b0;
                    inv_next   = 1'b0;
                    ret_next   = RET_CHECK;
                    state_next = ST_LP1;
                end
            end
            ST_LP1:
            begin
                state_next = ST_LP2;
            end
            ST_LP2:
            begin
                case (ret_reg)
                    RET_DAYS: state_next = ST_DAYS;
                    RET_FIX:  state_next = ST_FIX;
                    default:  state_next = ST_CHECK;
                endcase
            end
            ST_CHECK:
            begin
                if ((month_reg == '0) || (month_reg > gda_pkg::MONTH_DEC) ||
                    (day_reg == '0) || (day_reg > len))
                begin
                    inv_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if ((op_reg == gda_pkg::OP_DAYS) || (op_reg == gda_pkg::OP_WEEKS))
                begin
                    state_next = ST_DAYS;
                end
                else if (op_reg <= gda_pkg::OP_MILLENNIA)
                begin
                    state_next = ST_YMUL;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DAYS:
            begin
                // Advance one month per cycle, pausing for the leap evaluator after a year boundary
                year_next  = step.year;
                month_next = step.month;
                day_next   = step.day;
                rem_next   = step.rem;
                if (step.fin)
                begin
                    ovf_next   = step.ovf;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (step.year_inc)
                begin
                    ret_next   = RET_DAYS;
                    state_next = ST_LP1;
                end
            end
            ST_YMUL:
            begin
                prod_next  = gda_pkg::PROD_W'(rem_reg[gda_pkg::AMOUNT_W-1:0])
                           * gda_pkg::PROD_W'(gda_pkg::year_mult(op_reg));
                state_next = ST_YADD;
            end
            ST_YADD:
            begin
                if (new_year > {{(gda_pkg::PROD_W + 1 - gda_pkg::YEAR_W){1'b0}},
                                gda_pkg::YEAR_MAX})
                begin
                    year_next  = gda_pkg::YEAR_MAX;
                    month_next = gda_pkg::MONTH_DEC;
                    day_next   = gda_pkg::DAY_LAST;
                    ovf_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    year_next  = new_year[gda_pkg::YEAR_W-1:0];
                    ret_next   = RET_FIX;
                    state_next = ST_LP1;
                end
            end
            ST_FIX:
            begin
                // Clamp February 29 in a common year
                if (day_reg > len)
                    day_next = len;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_CHECK;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        rem_reg   <= rem_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        ovf_reg   <= ovf_next;
        inv_reg   <= inv_next;
        prod_reg  <= prod_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign result.out_year  = year_reg;
    assign result.out_month = month_reg;
    assign result.out_day   = day_reg;
    assign result.overflow  = ovf_reg;
    assign result.invalid   = inv_reg;

    // A result is only shown once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // A valid result always carries a real month and day
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.invalid) |->
        (result.out_month >= gda_pkg::MONTH_JAN && result.out_month <= gda_pkg::MONTH_DEC &&
         result.out_day != '0))
        else $error("valid result with impossible date");

    // Overflow and invalid never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.overflow && result.invalid))
        else $error("overflow flagged on an invalid date");

    // Saturation always lands on the last day of the last year
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |->
        (result.out_year == gda_pkg::YEAR_MAX && result.out_month == gda_pkg::MONTH_DEC &&
         result.out_day == gda_pkg::DAY_LAST))
        else $error("overflow result not saturated");

endmodule

// ===== hw/rtl/gda_leap.sv =====
// Two-stage leap-year evaluator built on a reciprocal multiply.
`timescale 1ns / 1ps

module gda_leap (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [gda_pkg::YEAR_W-1:0] year,
    output logic                      leap
);

    logic [gda_pkg::YEAR_W-1:0]   year_s1_reg;
    logic [gda_pkg::DIV25_PW-1:0] prod_s1_reg;
    logic                         leap_reg;
    logic [gda_pkg::DIV25_QW-1:0] quot;
    logic [gda_pkg::YEAR_W:0]     quot_x25;
    logic                         div100;
    logic                         leap_next;

    // Stage one: multiply by the reciprocal of 25
    always_ff @(posedge clk)
    begin
        year_s1_reg <= year;
        prod_s1_reg <= gda_pkg::DIV25_PW'(year) * gda_pkg::DIV25_PW'(gda_pkg::DIV25_MUL);
    end

    // Stage two: divisible by 4 and by 25 means divisible by 100; by 16 too means 400
    always_comb
    begin
        quot      = prod_s1_reg[gda_pkg::DIV25_PW-1:gda_pkg::DIV25_SHIFT];
        quot_x25  = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0} + {5'b0, quot};
        div100    = (year_s1_reg[1:0] == 2'b00) && (quot_x25 == {1'b0, year_s1_reg});
        leap_next = (year_s1_reg[1:0] == 2'b00) && (!div100 || (year_s1_reg[3:0] == 4'b0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            leap_reg <= 1'b0;
        else
            leap_reg <= leap_next;
    end

    assign leap = leap_reg;

endmodule

// ===== hw/rtl/gda_step.sv =====
// Month step unit: adds days in this month or moves to the next 1st, or saturates.
`timescale 1ns / 1ps

module gda_step (
    input  logic [gda_pkg::YEAR_W-1:0]  year,
    input  logic [gda_pkg::MONTH_W-1:0] month,
    input  logic [gda_pkg::DAY_W-1:0]   day,
    input  logic [gda_pkg::REM_W-1:0]   rem,
    input  logic                        leap,
    output gda_pkg::gda_step_t          step
);

    logic [gda_pkg::DAY_W-1:0] len;
    logic [gda_pkg::REM_W:0]   sum;
    logic [gda_pkg::REM_W-1:0] used;

    always_comb
    begin
        len  = gda_pkg::month_days(month, leap);
        sum  = {{(gda_pkg::REM_W + 1 - gda_pkg::DAY_W){1'b0}}, day} + {1'b0, rem};
        used = {{(gda_pkg::REM_W - gda_pkg::DAY_W){1'b0}}, len}
             - {{(gda_pkg::REM_W - gda_pkg::DAY_W){1'b0}}, day}
             + gda_pkg::REM_W'(1);

        step          = '0;
        step.year     = year;
        step.month    = month;
        step.day      = day;
        step.rem      = rem;

        if (rem == '0)
        begin
            // Nothing left to add
            step.fin = 1'b1;
        end
        else if (sum <= {{(gda_pkg::REM_W + 1 - gda_pkg::DAY_W){1'b0}}, len})
        begin
            // Land inside this month
            step.day = sum[gda_pkg::DAY_W-1:0];
            step.rem = '0;
            step.fin = 1'b1;
        end
        else
        begin
            // Drop the rest of this month and move to the first of the next
            step.rem = rem - used;
            step.day = 5'd1;
            if (month == gda_pkg::MONTH_DEC)
            begin
                if (year == gda_pkg::YEAR_MAX)
                begin
                    step.year  = gda_pkg::YEAR_MAX;
                    step.month = gda_pkg::MONTH_DEC;
                    step.day   = gda_pkg::DAY_LAST;
                    step.fin   = 1'b1;
                    step.ovf   = 1'b1;
                end
                else
                begin
                    step.year     = year + gda_pkg::YEAR_W'(1);
                    step.month    = gda_pkg::MONTH_JAN;
                    step.year_inc = 1'b1;
                end
            end
            else
            begin
                step.month = month + gda_pkg::MONTH_W'(1);
            end
        end
    end

endmodule
